[src/rc_pkg.sv]
// Shared types, codes and character helpers of the radix converter.
// No dependencies; every other file but rc_if.sv imports this package.
package rc_pkg;

  localparam int BASE_W = 5;
  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 5'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;

  typedef enum logic [0:0] {
    REG_SOURCE_BASE = 1'b0,
    REG_TARGET_BASE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic               known;
    logic [DIGIT_W-1:0] value;
  } digit_t;

  // Datapath enables of one microcode step.
  typedef struct packed {
    logic accept;
    logic check;
    logic divide;
    logic store;
    logic set_ovf;
    logic emit;
    logic status;
    logic clear;
  } ctrl_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic last_in;
    logic bad;
    logic bits_done;
    logic q_zero;
    logic room;
    logic cnt_one;
    logic out_free;
  } flags_t;

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.known = 1'b0;
    d.value = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.known = 1'b1;
      d.value = DIGIT_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d.known = 1'b1;
      d.value = DIGIT_W'(c - CHAR_UPPER_A + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < 4'd10) g = CHAR_ZERO + CHAR_W'(d);
    else g = CHAR_UPPER_A + CHAR_W'(d) - 8'd10;
    return g;
  endfunction

  function automatic logic base_ok(input logic [BASE_W-1:0] b);
    return (b >= BASE_MIN) && (b <= BASE_MAX);
  endfunction

endpackage

[src/rc_if.sv]
// Valid/ready channel interfaces of the radix converter: characters in, digits out.
// Depends on nothing; the decimal_value width follows VALUE_BITS.
interface rc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

interface rc_digit_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [7:0]            digit_code;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] decimal_value;
  logic                  last_digit;

  modport source(output valid, digit_code, status, decimal_value, last_digit, input ready);
  modport sink(input valid, digit_code, status, decimal_value, last_digit, output ready);
endinterface

[src/rc_cfg.sv]
// APB-style register file holding source_base and target_base.
// Depends on rc_pkg.
module rc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rc_pkg::APB_AW-1:0] paddr,
  input  logic [rc_pkg::APB_DW-1:0] pwdata,
  output logic [rc_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output logic [rc_pkg::BASE_W-1:0] source_base,
  output logic [rc_pkg::BASE_W-1:0] target_base
);
  import rc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SOURCE_BASE_RST;
      target_base <= TARGET_BASE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SOURCE_BASE: source_base <= pwdata[BASE_W-1:0];
        REG_TARGET_BASE: target_base <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_SOURCE_BASE: prdata = APB_DW'(source_base);
        REG_TARGET_BASE: prdata = APB_DW'(target_base);
        default: prdata = '0;
      endcase
    end
  end

endmodule

[src/rc_sequencer.sv]
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on rc_pkg (ctrl_t, flags_t).
module rc_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  rc_pkg::flags_t flags,
  output rc_pkg::ctrl_t  ctrl
);
  import rc_pkg::*;

  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_LAST,
    C_BAD,
    C_BITS_DONE,
    C_QZERO,
    C_ROOM,
    C_CNT_ONE
  } cond_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    logic  hold;
    step_t target;
  } uword_t;

  localparam step_t S_ACCEPT = 4'd0;
  localparam step_t S_CHECK  = 4'd1;
  localparam step_t S_DIVIDE = 4'd2;
  localparam step_t S_STORE  = 4'd3;
  localparam step_t S_ROOM   = 4'd4;
  localparam step_t S_OVF    = 4'd5;
  localparam step_t S_STATUS = 4'd6;
  localparam step_t S_EMIT   = 4'd7;
  localparam step_t S_DONE   = 4'd8;

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   stall;
  logic   taken;

  always_comb begin
    uw = '0;
    unique case (pc)
      S_ACCEPT: begin
        uw.ctrl.accept = 1'b1;
        uw.cond = C_LAST;
        uw.hold = 1'b1;
        uw.target = S_CHECK;
      end
      S_CHECK: begin
        uw.ctrl.check = 1'b1;
        uw.cond = C_BAD;
        uw.target = S_STATUS;
      end
      S_DIVIDE: begin
        uw.ctrl.divide = 1'b1;
        uw.cond = C_BITS_DONE;
        uw.hold = 1'b1;
        uw.target = S_STORE;
      end
      S_STORE: begin
        uw.ctrl.store = 1'b1;
        uw.cond = C_QZERO;
        uw.target = S_EMIT;
      end
      S_ROOM: begin
        uw.cond = C_ROOM;
        uw.target = S_DIVIDE;
      end
      S_OVF: begin
        uw.ctrl.set_ovf = 1'b1;
        uw.cond = C_NONE;
      end
      S_STATUS: begin
        uw.ctrl.status = 1'b1;
        uw.ctrl.clear = 1'b1;
        uw.cond = C_ALWAYS;
        uw.target = S_ACCEPT;
      end
      S_EMIT: begin
        uw.ctrl.emit = 1'b1;
        uw.cond = C_CNT_ONE;
        uw.hold = 1'b1;
        uw.target = S_DONE;
      end
      S_DONE: begin
        uw.ctrl.clear = 1'b1;
        uw.cond = C_ALWAYS;
        uw.target = S_ACCEPT;
      end
      default: begin
        uw.cond = C_ALWAYS;
        uw.target = S_ACCEPT;
      end
    endcase
  end

  assign stall = (uw.ctrl.emit | uw.ctrl.status) & ~flags.out_free;
  assign ctrl  = stall ? '0 : uw.ctrl;

  always_comb begin
    unique case (uw.cond)
      C_NONE:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_LAST:      taken = flags.last_in;
      C_BAD:       taken = flags.bad;
      C_BITS_DONE: taken = flags.bits_done;
      C_QZERO:     taken = flags.q_zero;
      C_ROOM:      taken = flags.room;
      C_CNT_ONE:   taken = flags.cnt_one;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    priority if (stall) pc_next = pc;
    else if (taken) pc_next = uw.target;
    else if (uw.hold) pc_next = pc;
    else pc_next = pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= S_ACCEPT;
    else pc <= pc_next;
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(pc)) else $error("step advanced while output stalled");

  a_bad_to_status: assert property (@(posedge clk) disable iff (rst)
    (pc == S_CHECK && flags.bad) |=> pc == S_STATUS)
    else $error("bad run did not branch to status step");

  a_reset_entry: assert property (@(posedge clk)
    rst |=> pc == S_ACCEPT) else $error("reset did not return to accept step");

endmodule

[src/rc_datapath.sv]
// Datapath: Horner accumulator, run checks, bit-serial divider by the target base,
// digit buffer and output register. Driven by rc_sequencer control words; uses rc_pkg.
module rc_datapath #(
  parameter int MAX_DIGITS = 16,
  parameter int VALUE_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rc_pkg::BASE_W-1:0] source_base,
  input  logic [rc_pkg::BASE_W-1:0] target_base,
  input  rc_pkg::ctrl_t             ctrl,
  output rc_pkg::flags_t            flags,
  rc_char_if.sink                   chars,
  rc_digit_if.source                digits
);
  import rc_pkg::*;

  localparam int CC_W   = $clog2(MAX_DIGITS + 2);
  localparam int ND_W   = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BC_W   = $clog2(VALUE_BITS);
  localparam int PROD_W = VALUE_BITS + BASE_W;

  logic [VALUE_BITS-1:0] acc;
  logic [CC_W-1:0]       char_count;
  logic                  invalid_seen;
  logic                  overflow_seen;
  logic [DIGIT_W-1:0]    digit_buffer [MAX_DIGITS];
  logic [ND_W-1:0]       ndig;
  logic [VALUE_BITS-1:0] quot;
  logic [DIGIT_W-1:0]    rem;
  logic [BC_W-1:0]       bitcnt;

  logic                  take;
  digit_t                dig;
  logic [CC_W-1:0]       char_count_next;
  logic                  bad_digit;
  logic [PROD_W-1:0]     prod;
  logic                  prod_ovf;
  logic                  bases_bad;
  logic [DIGIT_W:0]      trial;
  logic                  trial_ge;
  logic [DIGIT_W:0]      trial_diff;
  logic [ND_W-1:0]       rd_pos;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      wr_idx;

  assign chars.ready = ctrl.accept;
  assign take = chars.valid & ctrl.accept;

  assign dig = digit_of(chars.char_code);
  assign char_count_next = (char_count <= CC_W'(MAX_DIGITS)) ? char_count + 1'b1 : char_count;
  assign bad_digit = ~dig.known | ~base_ok(source_base) |
                     (BASE_W'(dig.value) >= source_base);
  assign prod = PROD_W'(acc) * PROD_W'(source_base) + PROD_W'(dig.value);
  assign prod_ovf = |prod[PROD_W-1:VALUE_BITS];
  assign bases_bad = ~base_ok(source_base) | ~base_ok(target_base);

  assign trial      = {rem, quot[VALUE_BITS-1]};
  assign trial_ge   = trial >= target_base;
  assign trial_diff = trial - target_base;

  assign rd_pos = ndig - 1'b1;
  assign rd_idx = rd_pos[IDX_W-1:0];
  assign wr_idx = ndig[IDX_W-1:0];

  always_comb begin
    flags.last_in   = take & chars.last_char;
    flags.bad       = invalid_seen | overflow_seen | bases_bad;
    flags.bits_done = (bitcnt == '0);
    flags.q_zero    = (quot == '0);
    flags.room      = (ndig != ND_W'(MAX_DIGITS));
    flags.cnt_one   = (ndig == ND_W'(1));
    flags.out_free  = ~digits.valid | digits.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      char_count    <= '0;
      invalid_seen  <= 1'b0;
      overflow_seen <= 1'b0;
      ndig          <= '0;
    end else begin
      if (take) begin
        char_count <= char_count_next;
        if (bad_digit || char_count_next > CC_W'(MAX_DIGITS)) invalid_seen <= 1'b1;
        if (!bad_digit && !overflow_seen) begin
          if (prod_ovf) overflow_seen <= 1'b1;
          else acc <= prod[VALUE_BITS-1:0];
        end
      end
      if (ctrl.check) begin
        if (bases_bad) invalid_seen <= 1'b1;
        ndig <= '0;
      end
      if (ctrl.store) ndig <= ndig + 1'b1;
      if (ctrl.set_ovf) overflow_seen <= 1'b1;
      if (ctrl.emit) ndig <= rd_pos;
      if (ctrl.clear) begin
        acc           <= '0;
        char_count    <= '0;
        invalid_seen  <= 1'b0;
        overflow_seen <= 1'b0;
        ndig          <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.check) begin
      quot   <= acc;
      rem    <= '0;
      bitcnt <= BC_W'(VALUE_BITS - 1);
    end
    if (ctrl.divide) begin
      quot   <= {quot[VALUE_BITS-2:0], trial_ge};
      rem    <= trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      bitcnt <= bitcnt - 1'b1;
    end
    if (ctrl.store) begin
      digit_buffer[wr_idx] <= rem;
      rem    <= '0;
      bitcnt <= BC_W'(VALUE_BITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) digits.valid <= 1'b0;
    else if (ctrl.emit || ctrl.status) digits.valid <= 1'b1;
    else if (digits.ready) digits.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      digits.digit_code    <= glyph_of(digit_buffer[rd_idx]);
      digits.status        <= STATUS_OK;
      digits.decimal_value <= acc;
      digits.last_digit    <= (ndig == ND_W'(1));
    end else if (ctrl.status) begin
      digits.digit_code    <= '0;
      digits.status        <= invalid_seen ? STATUS_INVALID : STATUS_OVERFLOW;
      digits.decimal_value <= '0;
      digits.last_digit    <= 1'b1;
    end
  end

  a_ndig_bound: assert property (@(posedge clk) disable iff (rst)
    ndig <= ND_W'(MAX_DIGITS)) else $error("digit count beyond buffer depth");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (digits.valid && digits.status != STATUS_OK) |->
      (digits.last_digit && digits.digit_code == '0 && digits.decimal_value == '0))
    else $error("status result carries digit data");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    ctrl.divide |-> (BASE_W'(rem) < target_base))
    else $error("remainder not below target base");

endmodule

[src/radix_converter_core.sv]
// Radix converter: digit characters in one base (2..16) in, digit characters in another out.
// Channel chars (rc_char_if): one ASCII digit per request, most significant first,
//   last_char marks the final one. Characters are taken one per cycle while ready is high.
// Channel digits (rc_digit_if): one request per output digit, most significant first,
//   with the decimal value; last_digit marks the end of the run. A bad run (unknown
//   character, digit not below base, base out of range, too long) gives one request
//   with status 1, an oversize value or rendering one with status 2.
// After the last character the sequencer runs a bit-serial divider by target_base, one
//   division per output digit, and all digits of a result are computed before the first
//   leaves. A status result for a bad run or an oversize value follows the check step
//   without division; one for an oversize rendering follows MAX_DIGITS divisions.
//   Digits leave one per cycle while the receiver takes them, and a clear step ends the
//   run before chars.ready rises again.
// chars.ready is low from the last character until the run has been handed to the
// output register. A stalled receiver holds the output register and the sequencer;
// the next run's characters are taken while the final result still waits.
// Reset (rst, synchronous) clears the run, sets source_base to 10, target_base to 2.
// Registers over APB: source_base at 0x0, target_base at 0x4; write only while idle.
module radix_converter_core #(
  parameter int MAX_DIGITS = 16,
  parameter int VALUE_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  rc_char_if.sink                   chars,
  rc_digit_if.source                digits,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rc_pkg::APB_AW-1:0] paddr,
  input  logic [rc_pkg::APB_DW-1:0] pwdata,
  output logic [rc_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import rc_pkg::*;

  logic [BASE_W-1:0] source_base;
  logic [BASE_W-1:0] target_base;
  ctrl_t             ctrl;
  flags_t            flags;

  rc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .source_base (source_base),
    .target_base (target_base)
  );

  rc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  rc_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .source_base (source_base),
    .target_base (target_base),
    .ctrl        (ctrl),
    .flags       (flags),
    .chars       (chars),
    .digits      (digits)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench of radix_converter_core: random and directed digit strings
// are checked against a predictor fed every accepted character, or a typed result.
// Depends on rc_pkg (src/rc_pkg.sv) and the channel interfaces (src/rc_if.sv).
module tb_top;
  import rc_pkg::*;

  localparam int MAX_DIGITS = 16;
  localparam int VALUE_BITS = 31;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
  localparam int RANDOM_ITEMS = 320;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [7:0]            code;
    status_t               st;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } digit_res_t;

  typedef struct {
    bit         cfg;
    reg_idx_t   reg_sel;
    logic [4:0] base;
    logic [7:0] ch;
    bit         last;
    bit         typed;
    digit_res_t res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        ch_valid = 1'b0;
  logic [7:0]  ch_code = '0;
  logic        ch_last = 1'b0;
  logic        digit_take = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic        pready;

  logic hold_go = 1'b0;
  logic calm = 1'b0;
  int   hold_left = 0;
  int   stall_cycles = 0;
  int   err_count = 0;

  logic [4:0]      src_base_m;
  logic [4:0]      tgt_base_m;
  longint unsigned acc_m;
  int unsigned     cnt_m;
  bit              inv_m;
  bit              ovf_m;

  digit_res_t run_digits[$];
  digit_res_t due_digits[$];
  plan_row_t  plan[$];

  rc_char_if chars_if ();
  rc_digit_if #(.VALUE_BITS(VALUE_BITS)) digits_if ();

  assign chars_if.valid = ch_valid;
  assign chars_if.char_code = ch_code;
  assign chars_if.last_char = ch_last;
  assign digits_if.ready = digit_take;

  radix_converter_core #(
    .MAX_DIGITS(MAX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .digits(digits_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit base_in(logic [4:0] b);
    return b >= 5'd2 && b <= 5'd16;
  endfunction

  function automatic int char_digit(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] glyph(int d);
    return (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d - 10);
  endfunction

  function automatic void clear_run();
    acc_m = 0;
    cnt_m = 0;
    inv_m = 0;
    ovf_m = 0;
  endfunction

  // Advance the predicted run by one character; results of a closed run go to run_digits.
  function automatic void convert_char(logic [7:0] c, bit last);
    int d;
    int n;
    int k;
    longint unsigned t;
    int digs[MAX_DIGITS];
    digit_res_t r;
    d = char_digit(c);
    if (cnt_m <= MAX_DIGITS) cnt_m++;
    if (cnt_m > MAX_DIGITS) inv_m = 1;
    if (d < 0 || !base_in(src_base_m) || d >= int'(src_base_m)) begin
      inv_m = 1;
    end else if (!ovf_m) begin
      if (acc_m > (VALUE_MAX - longint'(d)) / src_base_m) ovf_m = 1;
      else acc_m = acc_m * src_base_m + longint'(d);
    end
    if (!last) return;
    if (!base_in(src_base_m) || !base_in(tgt_base_m)) inv_m = 1;
    n = 0;
    if (!inv_m && !ovf_m) begin
      t = acc_m;
      do begin
        t = t / tgt_base_m;
        n++;
      end while (t > 0);
      if (n > MAX_DIGITS) ovf_m = 1;
    end
    if (inv_m || ovf_m) begin
      r.code = '0;
      r.st = inv_m ? STATUS_INVALID : STATUS_OVERFLOW;
      r.value = '0;
      r.last = 1'b1;
      run_digits.push_back(r);
    end else begin
      t = acc_m;
      for (k = n - 1; k >= 0; k--) begin
        digs[k] = int'(t % tgt_base_m);
        t = t / tgt_base_m;
      end
      for (k = 0; k < n; k++) begin
        r.code = glyph(digs[k]);
        r.st = STATUS_OK;
        r.value = acc_m[VALUE_BITS-1:0];
        r.last = (k == n - 1);
        run_digits.push_back(r);
      end
    end
    clear_run();
  endfunction

  task automatic report_err(string what, longint got, longint want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    err_count++;
  endtask

  task automatic send_char(logic [7:0] c, bit last, bit typed, digit_res_t fixed);
    if (!calm) begin
      while ($urandom_range(99) < 37) begin
        ch_valid <= 1'b0;
        @(posedge clk);
      end
    end
    ch_valid <= 1'b1;
    ch_code <= c;
    ch_last <= last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    run_digits.delete();
    convert_char(c, last);
    if (typed && last) due_digits.push_back(fixed);
    else foreach (run_digits[i]) due_digits.push_back(run_digits[i]);
  endtask

  task automatic settle();
    ch_valid <= 1'b0;
    do @(posedge clk); while (due_digits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(reg_idx_t r, logic [4:0] b);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= APB_DW'(b);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (r == REG_SOURCE_BASE) src_base_m = b;
    else tgt_base_m = b;
  endtask

  function automatic void cfg_row(reg_idx_t r, logic [4:0] b);
    plan_row_t p;
    p.cfg = 1;
    p.reg_sel = r;
    p.base = b;
    p.ch = '0;
    p.last = 0;
    p.typed = 0;
    p.res = '0;
    plan.push_back(p);
  endfunction

  // Typed rows close with one result: the given digit or status, value 0, last set.
  function automatic void text_rows(string s, bit typed, logic [7:0] code, status_t st);
    plan_row_t p;
    for (int i = 0; i < s.len(); i++) begin
      p.cfg = 0;
      p.reg_sel = REG_SOURCE_BASE;
      p.base = '0;
      p.ch = s[i];
      p.last = (i == s.len() - 1);
      p.typed = typed;
      p.res.code = code;
      p.res.st = st;
      p.res.value = '0;
      p.res.last = 1'b1;
      plan.push_back(p);
    end
  endfunction

  function automatic logic [4:0] pick_base();
    return ($urandom_range(99) < 85) ? 5'($urandom_range(2, 16)) : 5'($urandom_range(31));
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      digit_take <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      digit_take <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      digit_take <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    digit_res_t want;
    if (!rst && digits_if.valid && digit_take) begin
      if (due_digits.size() == 0) begin
        report_err("unexpected digit", digits_if.digit_code, 0);
      end else begin
        want = due_digits.pop_front();
        if (digits_if.digit_code !== want.code)
          report_err("digit_code", digits_if.digit_code, want.code);
        if (digits_if.status !== want.st)
          report_err("status", digits_if.status, want.st);
        if (digits_if.decimal_value !== want.value)
          report_err("decimal_value", digits_if.decimal_value, want.value);
        if (digits_if.last_digit !== want.last)
          report_err("last_digit", digits_if.last_digit, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ch_valid && chars_if.ready) || (digits_if.valid && digit_take) ||
        (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0] text[$];
    longint unsigned val;
    logic [4:0] rb;
    int items_sent;
    int run;
    int kind;
    int w;
    int spins;
    src_base_m = SOURCE_BASE_RST;
    tgt_base_m = TARGET_BASE_RST;
    clear_run();

    text_rows("0", 1, CHAR_ZERO, STATUS_OK);
    text_rows("f", 1, 8'h00, STATUS_INVALID);
    text_rows("A", 1, 8'h00, STATUS_INVALID);
    cfg_row(REG_SOURCE_BASE, 5'd31);
    text_rows("1", 1, 8'h00, STATUS_INVALID);
    cfg_row(REG_SOURCE_BASE, 5'd16);
    cfg_row(REG_TARGET_BASE, 5'd0);
    text_rows("1", 1, 8'h00, STATUS_INVALID);
    cfg_row(REG_TARGET_BASE, 5'd2);
    text_rows("FFFF", 0, 8'h00, STATUS_OK);
    text_rows("10000", 1, 8'h00, STATUS_OVERFLOW);
    text_rows("FFFFFFFFFFFFFFFFF", 1, 8'h00, STATUS_INVALID);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        settle();
        write_base(plan[i].reg_sel, plan[i].base);
      end else begin
        send_char(plan[i].ch, plan[i].last, plan[i].typed, plan[i].res);
      end
    end

    items_sent = 0;
    run = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (run % 6 == 0) begin
        settle();
        write_base(REG_SOURCE_BASE, (run == 0) ? 5'd2 : pick_base());
        write_base(REG_TARGET_BASE, (run == 0) ? 5'd16 : pick_base());
        if (run == 18) begin
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
      end
      calm <= (run >= 30 && run < 42);
      text.delete();
      kind = $urandom_range(99);
      if (kind < 88) begin
        w = ($urandom_range(3) == 0) ? $urandom_range(32) : $urandom_range(16);
        val = {$urandom, $urandom} & ((64'd1 << w) - 1);
        rb = base_in(src_base_m) ? src_base_m : 5'd10;
        do begin
          text.push_front(glyph(int'(val % rb)));
          val = val / rb;
        end while (val != 0);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) text.push_front(CHAR_ZERO);
        if (kind >= 76)
          text[$urandom_range(text.size() - 1)] = $urandom_range(1) ?
              8'($urandom_range(255)) : 8'h61 + 8'($urandom_range(5));
      end else begin
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(255)));
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 0, '0);
      items_sent += text.size();
      run++;
    end

    ch_valid <= 1'b0;
    calm <= 1'b0;
    spins = 0;
    while (due_digits.size() != 0 && spins < STALL_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_digits.size() != 0) report_err("digits never delivered", due_digits.size(), 0);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
src/rc_pkg.sv
src/rc_if.sv
src/rc_cfg.sv
src/rc_sequencer.sv
src/rc_datapath.sv
src/radix_converter_core.sv
verif/tb_top.sv
